// ----- rtl/pcz_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcz_pkg
// Shared types, constants and key table decode for the host key to
// keyboard matrix mapper.
// ----------------------------------------------------------------------------
package pcz_pkg;

    localparam int NUM_KEYS   = 40;
    localparam int STICK_W    = 5;
    localparam int KEY_W      = 8;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 48;

    localparam logic [KEY_W-1:0] KEY_SHIFT     = 8'h10;
    localparam logic [KEY_W-1:0] KEY_CTRL      = 8'h11;
    localparam logic [KEY_W-1:0] NUMPAD_FIRST  = 8'h60;
    localparam logic [KEY_W-1:0] NUMPAD_LAST   = 8'h69;
    localparam logic [KEY_W-1:0] NO_TARGET     = 8'd255;
    localparam logic [KEY_W-1:0] LONG_OFFSET   = 8'd132;
    localparam logic [KEY_W-1:0] CAPS_KEY      = 8'd0;
    localparam logic [KEY_W-1:0] SYM_SHIFT     = 8'd36;
    localparam logic [KEY_W-1:0] KEY_LIMIT     = 8'd40;

    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] first;
        logic [KEY_W-1:0] second;
        logic [KEY_W-1:0] offset;
    } lookup_t;

    function automatic lookup_t mk(logic [KEY_W-1:0] f, logic [KEY_W-1:0] s,
                                   logic [5:0] idx);
        lookup_t r;
        r.hit    = 1'b1;
        r.first  = f;
        r.second = s;
        r.offset = 8'(idx) * 8'd3;
        return r;
    endfunction

    function automatic lookup_t no_hit();
        lookup_t r;
        r = '0;
        return r;
    endfunction

    function automatic logic [STICK_W-1:0] stick_bit(logic [3:0] idx);
        logic [STICK_W-1:0] b;
        case (idx)
            4'd2:    b = 5'd4;
            4'd4:    b = 5'd2;
            4'd5:    b = 5'd16;
            4'd6:    b = 5'd1;
            4'd8:    b = 5'd8;
            default: b = 5'd0;
        endcase
        return b;
    endfunction

    // Rows shared by the control and plain tables up to the space bar.
    function automatic logic [6:0] base_row(logic [KEY_W-1:0] key);
        logic [6:0] r;
        case (key)
            KEY_CTRL: r = {1'b1, 6'd0};
            8'h5A:    r = {1'b1, 6'd1};
            8'h58:    r = {1'b1, 6'd2};
            8'h43:    r = {1'b1, 6'd3};
            8'h56:    r = {1'b1, 6'd4};
            8'h41:    r = {1'b1, 6'd5};
            8'h53:    r = {1'b1, 6'd6};
            8'h44:    r = {1'b1, 6'd7};
            8'h46:    r = {1'b1, 6'd8};
            8'h47:    r = {1'b1, 6'd9};
            8'h51:    r = {1'b1, 6'd10};
            8'h57:    r = {1'b1, 6'd11};
            8'h45:    r = {1'b1, 6'd12};
            8'h52:    r = {1'b1, 6'd13};
            8'h54:    r = {1'b1, 6'd14};
            8'h31:    r = {1'b1, 6'd15};
            8'h32:    r = {1'b1, 6'd16};
            8'h33:    r = {1'b1, 6'd17};
            8'h34:    r = {1'b1, 6'd18};
            8'h35:    r = {1'b1, 6'd19};
            8'h30:    r = {1'b1, 6'd20};
            8'h39:    r = {1'b1, 6'd21};
            8'h38:    r = {1'b1, 6'd22};
            8'h37:    r = {1'b1, 6'd23};
            8'h36:    r = {1'b1, 6'd24};
            8'h50:    r = {1'b1, 6'd25};
            8'h4F:    r = {1'b1, 6'd26};
            8'h49:    r = {1'b1, 6'd27};
            8'h55:    r = {1'b1, 6'd28};
            8'h59:    r = {1'b1, 6'd29};
            8'h0D:    r = {1'b1, 6'd30};
            8'h4C:    r = {1'b1, 6'd31};
            8'h4B:    r = {1'b1, 6'd32};
            8'h4A:    r = {1'b1, 6'd33};
            8'h48:    r = {1'b1, 6'd34};
            8'h20:    r = {1'b1, 6'd35};
            default:  r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic lookup_t search_ctrl(logic [KEY_W-1:0] key);
        lookup_t    r;
        logic [6:0] b;
        b = base_row(key);
        if (b[6])
        begin
            r = mk(8'd0, 8'(b[5:0]), b[5:0]);
        end
        else
        begin
            case (key)
                KEY_SHIFT: r = mk(8'd0, 8'd36, 6'd36);
                8'h4D:     r = mk(8'd0, 8'd37, 6'd37);
                8'h4E:     r = mk(8'd0, 8'd38, 6'd38);
                8'h42:     r = mk(8'd0, 8'd39, 6'd39);
                default:   r = no_hit();
            endcase
        end
        return r;
    endfunction

    function automatic lookup_t search_plain(logic [KEY_W-1:0] key);
        lookup_t    r;
        logic [6:0] b;
        b = base_row(key);
        if (b[6])
        begin
            r = mk(NO_TARGET, 8'(b[5:0]), b[5:0]);
        end
        else
        begin
            case (key)
                8'h4D:   r = mk(NO_TARGET, 8'd37, 6'd36);
                8'h4E:   r = mk(NO_TARGET, 8'd38, 6'd37);
                8'h42:   r = mk(NO_TARGET, 8'd39, 6'd38);
                8'd8:    r = mk(8'd0, 8'd20, 6'd39);
                8'd37:   r = mk(8'd0, 8'd19, 6'd40);
                8'd38:   r = mk(8'd0, 8'd23, 6'd41);
                8'd39:   r = mk(8'd0, 8'd22, 6'd42);
                8'd40:   r = mk(8'd0, 8'd24, 6'd43);
                8'd186:  r = mk(8'd36, 8'd26, 6'd44);
                8'd222:  r = mk(8'd36, 8'd23, 6'd45);
                8'd219:  r = mk(8'd36, 8'd29, 6'd46);
                8'd221:  r = mk(8'd36, 8'd28, 6'd47);
                8'd188:  r = mk(8'd36, 8'd38, 6'd48);
                8'd190:  r = mk(8'd36, 8'd37, 6'd49);
                8'd191:  r = mk(8'd36, 8'd4, 6'd50);
                8'd189:  r = mk(8'd36, 8'd33, 6'd51);
                8'd187:  r = mk(8'd36, 8'd31, 6'd52);
                8'd220:  r = mk(8'd36, 8'd7, 6'd53);
                default: r = no_hit();
            endcase
        end
        return r;
    endfunction

    // The shift table has ten padding rows between the letter rows and
    // the punctuation rows; they never match but shift the row numbers.
    function automatic lookup_t search_shift(logic [KEY_W-1:0] key);
        lookup_t r;
        case (key)
            KEY_CTRL: r = mk(8'd36, 8'd0, 6'd0);
            8'h5A:    r = mk(8'd36, 8'd1, 6'd1);
            8'h58:    r = mk(8'd36, 8'd2, 6'd2);
            8'h43:    r = mk(8'd36, 8'd3, 6'd3);
            8'h56:    r = mk(8'd36, 8'd4, 6'd4);
            8'h41:    r = mk(8'd36, 8'd5, 6'd5);
            8'h53:    r = mk(8'd36, 8'd6, 6'd6);
            8'h44:    r = mk(8'd36, 8'd7, 6'd7);
            8'h46:    r = mk(8'd36, 8'd8, 6'd8);
            8'h47:    r = mk(8'd36, 8'd9, 6'd9);
            8'h51:    r = mk(8'd36, 8'd10, 6'd10);
            8'h57:    r = mk(8'd36, 8'd11, 6'd11);
            8'h45:    r = mk(8'd36, 8'd12, 6'd12);
            8'h52:    r = mk(8'd36, 8'd13, 6'd13);
            8'h54:    r = mk(8'd36, 8'd14, 6'd14);
            8'h31:    r = mk(8'd36, 8'd15, 6'd15);
            8'h32:    r = mk(8'd36, 8'd16, 6'd16);
            8'h33:    r = mk(8'd36, 8'd17, 6'd17);
            8'h34:    r = mk(8'd36, 8'd18, 6'd18);
            8'h35:    r = mk(8'd36, 8'd19, 6'd19);
            8'h50:    r = mk(8'd36, 8'd25, 6'd20);
            8'h4F:    r = mk(8'd36, 8'd26, 6'd21);
            8'h49:    r = mk(8'd36, 8'd27, 6'd22);
            8'h55:    r = mk(8'd36, 8'd28, 6'd23);
            8'h59:    r = mk(8'd36, 8'd29, 6'd24);
            8'h0D:    r = mk(8'd36, 8'd30, 6'd25);
            8'h4C:    r = mk(8'd36, 8'd31, 6'd26);
            8'h4B:    r = mk(8'd36, 8'd32, 6'd27);
            8'h4A:    r = mk(8'd36, 8'd33, 6'd28);
            8'h48:    r = mk(8'd36, 8'd34, 6'd29);
            8'h20:    r = mk(8'd36, 8'd35, 6'd30);
            8'h4D:    r = mk(8'd36, 8'd37, 6'd31);
            8'h4E:    r = mk(8'd36, 8'd38, 6'd32);
            8'h42:    r = mk(8'd36, 8'd39, 6'd33);
            8'd186:   r = mk(8'd36, 8'd1, 6'd44);
            8'd222:   r = mk(8'd36, 8'd25, 6'd45);
            8'd219:   r = mk(8'd36, 8'd8, 6'd46);
            8'd221:   r = mk(8'd36, 8'd9, 6'd47);
            8'd188:   r = mk(8'd36, 8'd13, 6'd48);
            8'd190:   r = mk(8'd36, 8'd14, 6'd49);
            8'd191:   r = mk(8'd36, 8'd3, 6'd50);
            8'd189:   r = mk(8'd36, 8'd20, 6'd51);
            8'd187:   r = mk(8'd36, 8'd32, 6'd52);
            8'd220:   r = mk(8'd36, 8'd6, 6'd53);
            8'h36:    r = mk(8'd36, 8'd23, 6'd54);
            8'h37:    r = mk(8'd36, 8'd24, 6'd55);
            8'h38:    r = mk(8'd36, 8'd39, 6'd56);
            8'h39:    r = mk(8'd36, 8'd22, 6'd57);
            8'h30:    r = mk(8'd36, 8'd21, 6'd58);
            default:  r = no_hit();
        endcase
        return r;
    endfunction

    function automatic logic [NUM_KEYS-1:0] drive_key(logic [NUM_KEYS-1:0] m,
                                                      logic [KEY_W-1:0] k,
                                                      logic down);
        logic [NUM_KEYS-1:0] r;
        r = m;
        if (k < KEY_LIMIT)
        begin
            r[k[5:0]] = ~down;
        end
        return r;
    endfunction

endpackage

// ----- rtl/pcz_key_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcz_key_lookup
// Table search: the shift table first when shift is held, then the control
// or plain table.
// ----------------------------------------------------------------------------
module pcz_key_lookup
    import pcz_pkg::*;
(
    input  logic [KEY_W-1:0] key,
    input  logic             shift_down,
    input  logic             ctrl_down,
    output lookup_t          entry
);

    lookup_t shift_entry;
    lookup_t other_entry;

    always_comb
    begin
        shift_entry = search_shift(key);
        other_entry = ctrl_down ? search_ctrl(key) : search_plain(key);
        if (shift_down && shift_entry.hit)
        begin
            entry = shift_entry;
        end
        else
        begin
            entry = other_entry;
        end
    end

endmodule

// ----- rtl/pc_key_to_zx_matrix_mapper_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_key_to_zx_matrix_mapper_core
// Maps host key events onto an emulated 8x5 keyboard matrix and joystick.
// ----------------------------------------------------------------------------
// Each slave transaction carries one host key event. The block answers every
// event with exactly one master transaction that holds the whole 40-bit
// active-low matrix, the 5-bit joystick register and a match flag.
// An event is captured in an input register, decoded against the key tables
// and applied to the matrix state, and the result is held in an output
// register. Throughput is one event per cycle while the receiver does not
// stall; the state update of one event completes before the next event is
// decoded, so events may follow each other back to back.
// When the receiver stalls, the output register holds its transaction and
// one more event waits in the input register; s_tready then drops until
// the result is taken.
// Reset releases all matrix keys, clears the joystick, the remembered key
// and the previous entry, and empties both registers.
// ----------------------------------------------------------------------------
module pc_key_to_zx_matrix_mapper_core
    import pcz_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // key_code[7:0], key_pressed[8], shift_down[9], ctrl_down[10],
    // last_key_down[11], zero[15:12]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // matrix_bits[39:0], joystick_bits[44:40], matched[45], zero[47:46]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic                in_valid_reg;
    logic [KEY_W-1:0]    key_code_reg;
    logic                key_pressed_reg;
    logic                shift_down_reg;
    logic                ctrl_down_reg;
    logic                last_key_down_reg;

    logic [NUM_KEYS-1:0] key_matrix_reg;
    logic [NUM_KEYS-1:0] key_matrix_next;
    logic [STICK_W-1:0]  stick_reg;
    logic [STICK_W-1:0]  stick_next;
    logic [KEY_W-1:0]    remembered_reg;
    logic [KEY_W-1:0]    remembered_next;
    logic [KEY_W-1:0]    prev_first_reg;
    logic [KEY_W-1:0]    prev_first_next;
    logic [KEY_W-1:0]    prev_second_reg;
    logic [KEY_W-1:0]    prev_second_next;
    logic [KEY_W-1:0]    prev_offset_reg;
    logic [KEY_W-1:0]    prev_offset_next;
    logic                matched_next;

    logic                out_valid_reg;
    logic [NUM_KEYS-1:0] out_matrix_reg;
    logic [STICK_W-1:0]  out_stick_reg;
    logic                out_matched_reg;

    logic                advance;
    logic                numpad;
    logic [KEY_W-1:0]    eff_key;
    logic                eff_down;
    lookup_t             entry;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_matched_reg, out_stick_reg, out_matrix_reg};

    assign numpad   = (key_code_reg >= NUMPAD_FIRST) && (key_code_reg <= NUMPAD_LAST);
    assign eff_key  = (key_code_reg == KEY_SHIFT) ? remembered_reg : key_code_reg;
    assign eff_down = (key_code_reg == KEY_SHIFT) ? last_key_down_reg : key_pressed_reg;

    pcz_key_lookup u_lookup
    (
        .key        (eff_key),
        .shift_down (shift_down_reg),
        .ctrl_down  (ctrl_down_reg),
        .entry      (entry)
    );

    always_comb
    begin
        logic [NUM_KEYS-1:0] m;
        logic [STICK_W-1:0]  b;
        m                = key_matrix_reg;
        b                = stick_bit(key_code_reg[3:0]);
        stick_next       = stick_reg;
        remembered_next  = remembered_reg;
        prev_first_next  = prev_first_reg;
        prev_second_next = prev_second_reg;
        prev_offset_next = prev_offset_reg;
        matched_next     = 1'b0;
        if (numpad)
        begin
            stick_next   = key_pressed_reg ? (stick_reg | b) : (stick_reg & ~b);
            matched_next = 1'b1;
        end
        else
        begin
            if ((eff_key != KEY_CTRL) && (eff_key != KEY_SHIFT))
            begin
                remembered_next = eff_key;
            end
            if (entry.hit)
            begin
                matched_next = 1'b1;
                if (prev_offset_reg >= LONG_OFFSET)
                begin
                    m = drive_key(m, prev_first_reg, 1'b0);
                    m = drive_key(m, prev_second_reg, 1'b0);
                end
                if (entry.first == NO_TARGET)
                begin
                    m = drive_key(m, CAPS_KEY, 1'b0);
                    m = drive_key(m, SYM_SHIFT, 1'b0);
                end
                else
                begin
                    m = drive_key(m, entry.first, eff_down);
                end
                m                = drive_key(m, entry.second, eff_down);
                prev_first_next  = entry.first;
                prev_second_next = entry.second;
                prev_offset_next = entry.offset;
            end
        end
        key_matrix_next = m;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            key_matrix_reg  <= '1;
            stick_reg       <= '0;
            remembered_reg  <= '0;
            prev_first_reg  <= '0;
            prev_second_reg <= '0;
            prev_offset_reg <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                key_matrix_reg  <= key_matrix_next;
                stick_reg       <= stick_next;
                remembered_reg  <= remembered_next;
                prev_first_reg  <= prev_first_next;
                prev_second_reg <= prev_second_next;
                prev_offset_reg <= prev_offset_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            key_code_reg      <= s_tdata[7:0];
            key_pressed_reg   <= s_tdata[8];
            shift_down_reg    <= s_tdata[9];
            ctrl_down_reg     <= s_tdata[10];
            last_key_down_reg <= s_tdata[11];
        end
        if (advance)
        begin
            out_matrix_reg  <= key_matrix_next;
            out_stick_reg   <= stick_next;
            out_matched_reg <= matched_next;
        end
    end

endmodule

// ----- rtl/pcz_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcz_checker
// Port-level checks for the key to matrix mapper, bound to the top level.
// ----------------------------------------------------------------------------
module pcz_checker
    import pcz_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled master transaction changed.");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[47:46] == 2'b00)
        else $error("Padding bits of the result are not zero.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("Input blocked while no result is pending.");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("Result appeared without an accepted event two cycles earlier.");

endmodule

bind pc_key_to_zx_matrix_mapper_core pcz_checker u_pcz_checker (.*);
